// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the date unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/cda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

  localparam logic [11:0] FirstYear    = 12'd1900;
  localparam logic [11:0] LastYear     = 12'd2099;
  localparam logic [11:0] DefaultYear  = 12'd2000;
  localparam logic [7:0]  LastYearOff  = 8'(LastYear - FirstYear);
  localparam logic [16:0] LastSerial   = 17'd73049;
  // day number of 2000-01-01
  localparam logic [16:0] ResetSerial  = 17'd36525;
  localparam logic [8:0]  YearDays     = 9'd365;
  localparam logic [8:0]  LeapYearDays = 9'd366;

  typedef enum logic [2:0] {
    CMD_SET  = 3'd0,
    CMD_LOAD = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_CMP  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // request to the walker: date to day number, or day number to date
  typedef struct packed {
    logic        to_serial;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] serial;
  } walk_req_t;

  typedef struct packed {
    logic        done;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] serial;
  } walk_rsp_t;

  // valid for years 1900..2099 only: 1900 is the one century year in range
  // that is not a leap year
  function automatic logic is_leap_year(input logic [11:0] year);
    is_leap_year = (year[1:0] == 2'b00) && (year != FirstYear);
  endfunction

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
    case (month)
      4'd2:                      month_days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
      default:                   month_days = 5'd31;
    endcase
  endfunction

  function automatic date_t clamp_date(input logic [11:0] year, input logic [3:0] month,
                                       input logic [4:0] day);
    date_t r;
    r.year  = (year < FirstYear || year > LastYear) ? DefaultYear : year;
    r.month = (month < 4'd1 || month > 4'd12) ? 4'd1 : month;
    r.day   = (day < 5'd1 || day > month_days(is_leap_year(r.year), r.month)) ? 5'd1 : day;
    clamp_date = r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cda_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cda_walk (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire cda_pkg::walk_req_t req_i,
  output cda_pkg::walk_rsp_t      rsp_o
);

  typedef enum logic [2:0] {
    W_IDLE  = 3'b001,
    W_YEAR  = 3'b010,
    W_MONTH = 3'b100
  } wphase_e;

  wphase_e     phase_q, phase_d;
  logic        to_q, to_d;
  logic [7:0]  yr_q, yr_d;
  logic [3:0]  mo_q, mo_d;
  logic [16:0] acc_q, acc_d;
  logic [7:0]  tyr_q, tyr_d;
  logic [3:0]  tmo_q, tmo_d;
  logic [4:0]  tday_q, tday_d;
  logic        done_q, done_d;

  logic        leap;
  logic [8:0]  op;
  logic [17:0] res;
  logic        gt;

  // shared add / subtract unit
  always_comb begin
    leap = (yr_q[1:0] == 2'b00) && (yr_q != 8'd0);
    if (phase_q == W_YEAR) begin
      op = leap ? cda_pkg::LeapYearDays : cda_pkg::YearDays;
    end else if (to_q && (mo_q == tmo_q)) begin
      op = {4'd0, tday_q};
    end else begin
      op = {4'd0, cda_pkg::month_days(leap, mo_q)};
    end
    res = to_q ? ({1'b0, acc_q} + {9'd0, op}) : ({1'b0, acc_q} - {9'd0, op});
    gt  = !res[17] && (res[16:0] != 17'd0);
  end

  always_comb begin
    phase_d = phase_q;
    to_d    = to_q;
    yr_d    = yr_q;
    mo_d    = mo_q;
    acc_d   = acc_q;
    tyr_d   = tyr_q;
    tmo_d   = tmo_q;
    tday_d  = tday_q;
    done_d  = 1'b0;
    case (phase_q)
      W_IDLE: begin
        if (start_i) begin
          to_d    = req_i.to_serial;
          yr_d    = 8'd0;
          mo_d    = 4'd1;
          acc_d   = req_i.to_serial ? 17'd0 : req_i.serial;
          tyr_d   = 8'(req_i.year - cda_pkg::FirstYear);
          tmo_d   = req_i.month;
          tday_d  = req_i.day;
          phase_d = W_YEAR;
        end
      end
      W_YEAR: begin
        if (to_q) begin
          if (yr_q < tyr_q) begin
            acc_d = res[16:0];
            yr_d  = yr_q + 8'd1;
          end else begin
            phase_d = W_MONTH;
          end
        end else if (gt && (yr_q < cda_pkg::LastYearOff)) begin
          acc_d = res[16:0];
          yr_d  = yr_q + 8'd1;
        end else begin
          phase_d = W_MONTH;
        end
      end
      W_MONTH: begin
        if (to_q) begin
          acc_d = res[16:0];
          if (mo_q == tmo_q) begin
            done_d  = 1'b1;
            phase_d = W_IDLE;
          end else begin
            mo_d = mo_q + 4'd1;
          end
        end else if ((mo_q < 4'd12) && gt) begin
          acc_d = res[16:0];
          mo_d  = mo_q + 4'd1;
        end else begin
          done_d  = 1'b1;
          phase_d = W_IDLE;
        end
      end
      default: phase_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= W_IDLE;
      to_q    <= 1'b0;
      yr_q    <= 8'd0;
      mo_q    <= 4'd1;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      to_q    <= to_d;
      yr_q    <= yr_d;
      mo_q    <= mo_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    tyr_q  <= tyr_d;
    tmo_q  <= tmo_d;
    tday_q <= tday_d;
  end

  always_comb begin
    rsp_o.done   = done_q;
    rsp_o.year   = cda_pkg::FirstYear + {4'd0, yr_q};
    rsp_o.month  = mo_q;
    rsp_o.day    = acc_q[4:0];
    rsp_o.serial = acc_q;
  end

  `ASSERT_RST(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q)
  `ASSERT_RST(a_year_range, clk_i, rst_ni, yr_q <= cda_pkg::LastYearOff)
  `ASSERT_RST(a_month_range, clk_i, rst_ni, (mo_q >= 4'd1) && (mo_q <= 4'd12))

endmodule

`default_nettype wire

// ===== rtl/core/calendar_date_arithmetic_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// sequence: an unused command goes from idle straight to hold; set and compare first walk
// from 1900 up to the given date; load, add and subtract walk the day number down to a date
// one word at a time: the next word is taken in the cycle after the result is loaded
// the walk length is set by the single shared add / subtract unit, one year or month per cycle
// reset (async, active low): date 2000-01-01, day number 36525, no result pending

`include "assert_macros.svh"

module calendar_date_arithmetic_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [11:0]        year_in_i,
  input  wire logic [3:0]         month_in_i,
  input  wire logic [4:0]         day_in_i,
  input  wire logic [16:0]        count_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [11:0]             year_out_o,
  output logic [3:0]              month_out_o,
  output logic [4:0]              day_out_o,
  output logic [16:0]             serial_out_o,
  output logic signed [17:0]      difference_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e            state_q, state_d;
  cda_pkg::cmd_e     cmd_q, cmd_d;
  logic [11:0]       cur_year_q, cur_year_d;
  logic [3:0]        cur_month_q, cur_month_d;
  logic [4:0]        cur_day_q, cur_day_d;
  // day number of the stored date, kept alongside it
  logic [16:0]       serial_q, serial_d;
  logic [17:0]       diff_q, diff_d;

  logic              out_valid_q;
  logic [11:0]       year_out_q;
  logic [3:0]        month_out_q;
  logic [4:0]        day_out_q;
  logic [16:0]       serial_out_q;
  logic [17:0]       diff_out_q;
  logic              out_load;

  cda_pkg::walk_req_t w_req;
  cda_pkg::walk_rsp_t w_rsp;
  logic               w_start;

  cda_pkg::cmd_e     cmd_in;
  cda_pkg::date_t    set_date;
  cda_pkg::date_t    cmp_date;
  logic [17:0]       sum;
  logic [16:0]       n_sel;

  assign cmd_in = cda_pkg::cmd_e'(cmd_i);

  // operand preparation: field merge and clamp, target day number with saturation
  always_comb begin
    set_date = cda_pkg::clamp_date(
      (year_in_i == 12'd0) ? cur_year_q : year_in_i,
      (month_in_i == 4'd0) ? cur_month_q : month_in_i,
      (day_in_i == 5'd0) ? cur_day_q : day_in_i);
    // on compare zero fields are just bad values
    cmp_date = cda_pkg::clamp_date(year_in_i, month_in_i, day_in_i);
    sum = {1'b0, serial_q} + {1'b0, count_in_i};
    case (cmd_in)
      cda_pkg::CMD_ADD: begin
        n_sel = (sum > {1'b0, cda_pkg::LastSerial}) ? cda_pkg::LastSerial : sum[16:0];
      end
      cda_pkg::CMD_SUB: begin
        n_sel = (count_in_i >= serial_q) ? 17'd1 : (serial_q - count_in_i);
      end
      default: begin
        // load from a day number
        if (count_in_i == 17'd0) begin
          n_sel = 17'd1;
        end else if (count_in_i > cda_pkg::LastSerial) begin
          n_sel = cda_pkg::LastSerial;
        end else begin
          n_sel = count_in_i;
        end
      end
    endcase
  end

  // command sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_year_d  = cur_year_q;
    cur_month_d = cur_month_q;
    cur_day_d   = cur_day_q;
    serial_d    = serial_q;
    diff_d      = diff_q;
    w_start     = 1'b0;
    w_req       = '0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = cmd_in;
          diff_d = 18'd0;
          case (cmd_in)
            cda_pkg::CMD_SET: begin
              // new date takes effect now, its day number comes from the walk
              cur_year_d      = set_date.year;
              cur_month_d     = set_date.month;
              cur_day_d       = set_date.day;
              w_start         = 1'b1;
              w_req.to_serial = 1'b1;
              w_req.year      = set_date.year;
              w_req.month     = set_date.month;
              w_req.day       = set_date.day;
              state_d         = ST_WALK;
            end
            cda_pkg::CMD_LOAD, cda_pkg::CMD_ADD, cda_pkg::CMD_SUB: begin
              // day number known now, the date comes from the walk
              serial_d        = n_sel;
              w_start         = 1'b1;
              w_req.to_serial = 1'b0;
              w_req.serial    = n_sel;
              state_d         = ST_WALK;
            end
            cda_pkg::CMD_CMP: begin
              w_start         = 1'b1;
              w_req.to_serial = 1'b1;
              w_req.year      = cmp_date.year;
              w_req.month     = cmp_date.month;
              w_req.day       = cmp_date.day;
              state_d         = ST_WALK;
            end
            default: state_d = ST_HOLD;
          endcase
        end
      end
      ST_WALK: begin
        if (w_rsp.done) begin
          case (cmd_q)
            cda_pkg::CMD_SET: serial_d = w_rsp.serial;
            cda_pkg::CMD_CMP: diff_d = {1'b0, serial_q} - {1'b0, w_rsp.serial};
            default: begin
              cur_year_d  = w_rsp.year;
              cur_month_d = w_rsp.month;
              cur_day_d   = w_rsp.day;
            end
          endcase
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for a free output register
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  cda_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (w_start),
    .req_i   (w_req),
    .rsp_o   (w_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= cda_pkg::CMD_SET;
      cur_year_q  <= cda_pkg::DefaultYear;
      cur_month_q <= 4'd1;
      cur_day_q   <= 5'd1;
      serial_q    <= cda_pkg::ResetSerial;
      diff_q      <= 18'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      cur_year_q  <= cur_year_d;
      cur_month_q <= cur_month_d;
      cur_day_q   <= cur_day_d;
      serial_q    <= serial_d;
      diff_q      <= diff_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      year_out_q   <= cur_year_q;
      month_out_q  <= cur_month_q;
      day_out_q    <= cur_day_q;
      serial_out_q <= serial_q;
      diff_out_q   <= diff_q;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign year_out_o   = year_out_q;
  assign month_out_o  = month_out_q;
  assign day_out_o    = day_out_q;
  assign serial_out_o = serial_out_q;
  assign difference_o = $signed(diff_out_q);

  `ASSERT_RST(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
  `ASSERT_RST(a_done_in_walk, clk_i, rst_ni, w_rsp.done |-> (state_q == ST_WALK))
  `ASSERT_RST(a_serial_range, clk_i, rst_ni, (serial_q >= 17'd1) && (serial_q <= cda_pkg::LastSerial))
  `ASSERT_ALWAYS(a_no_word_in_reset, clk_i, !rst_ni |-> !out_valid_o)

endmodule

`default_nettype wire

// ===== tb/calendar_date_checker.sv =====
`timescale 1ns / 1ps

module calendar_date_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         cmd_i,
  input  logic [11:0]        year_in_i,
  input  logic [3:0]         month_in_i,
  input  logic [4:0]         day_in_i,
  input  logic [16:0]        count_in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [11:0]        year_out_i,
  input  logic [3:0]         month_out_i,
  input  logic [4:0]         day_out_i,
  input  logic [16:0]        serial_out_i,
  input  logic signed [17:0] difference_i,
  output int                 mismatches_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [11:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [16:0]        serial;
    logic signed [17:0] diff;
  } date_word_t;

  cda_pkg::date_t held_date;
  date_word_t     dates_due[$];
  int             mismatches;

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(int y, int m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // 1900-01-01 is day 1
  function automatic int day_number(cda_pkg::date_t dt);
    int n;
    n = dt.day;
    for (int t = cda_pkg::FirstYear; t < dt.year; t++) n += leap_year(t) ? 366 : 365;
    for (int t = 1; t < dt.month; t++) n += month_length(dt.year, t);
    return n;
  endfunction

  function automatic cda_pkg::date_t date_of_day(int n);
    cda_pkg::date_t r;
    int             y;
    int             m;
    if (n < 1) n = 1;
    if (n > cda_pkg::LastSerial) n = cda_pkg::LastSerial;
    y = cda_pkg::FirstYear;
    while (n > (leap_year(y) ? 366 : 365) && y < cda_pkg::LastYear) begin
      n -= leap_year(y) ? 366 : 365;
      y++;
    end
    m = 1;
    while (m < 12 && n > month_length(y, m)) begin
      n -= month_length(y, m);
      m++;
    end
    r.year  = 12'(y);
    r.month = 4'(m);
    r.day   = 5'(n);
    return r;
  endfunction

  // out of range fields fall back to 2000, january, day 1
  function automatic cda_pkg::date_t legal_date(int y, int m, int d);
    cda_pkg::date_t r;
    r.year  = (y < cda_pkg::FirstYear || y > cda_pkg::LastYear) ? cda_pkg::DefaultYear
                                                                : 12'(y);
    r.month = (m < 1 || m > 12) ? 4'd1 : 4'(m);
    r.day   = (d < 1 || d > month_length(r.year, r.month)) ? 5'd1 : 5'(d);
    return r;
  endfunction

  // updates the held date and returns the word the unit should give back
  function automatic date_word_t apply_command(logic [2:0] c, int y, int m, int d, int n);
    date_word_t w;
    int         s;
    w.diff = '0;
    case (c)
      cda_pkg::CMD_SET: begin
        if (y == 0) y = held_date.year;
        if (m == 0) m = held_date.month;
        if (d == 0) d = held_date.day;
        held_date = legal_date(y, m, d);
      end
      cda_pkg::CMD_LOAD: held_date = date_of_day(n);
      cda_pkg::CMD_ADD:  held_date = date_of_day(day_number(held_date) + n);
      cda_pkg::CMD_SUB: begin
        s = day_number(held_date);
        held_date = date_of_day((n >= s) ? 1 : s - n);
      end
      cda_pkg::CMD_CMP: begin
        w.diff = 18'(day_number(held_date) - day_number(legal_date(y, m, d)));
      end
      default: ;
    endcase
    w.year   = held_date.year;
    w.month  = held_date.month;
    w.day    = held_date.day;
    w.serial = 17'(day_number(held_date));
    return w;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    date_word_t want;
    if (!rst_ni) begin
      dates_due.delete();
      held_date  = '{year: cda_pkg::DefaultYear, month: 4'd1, day: 5'd1};
      mismatches = 0;
    end else begin
      // result first: it belongs to a word taken at an earlier edge
      if (out_valid_i && !out_stall_i) begin
        if (dates_due.size() == 0) begin
          report_mismatch("result word with no command waiting");
        end else begin
          want = dates_due.pop_front();
          check_field("year", year_out_i, want.year);
          check_field("month", month_out_i, want.month);
          check_field("day", day_out_i, want.day);
          check_field("serial", serial_out_i, want.serial);
          check_field("difference", difference_i, want.diff);
        end
      end
      if (in_valid_i && !in_stall_i)
        dates_due.push_back(apply_command(cmd_i, year_in_i, month_in_i, day_in_i, count_in_i));
    end
    mismatches_o <= mismatches;
    pending_o    <= dates_due.size();
  end

endmodule

// ===== tb/tb_calendar_date_arithmetic_unit.sv =====
`timescale 1ns / 1ps

module tb_calendar_date_arithmetic_unit;

  // cycles with no word moving on either side before the run is abandoned
  localparam int QuietLimit  = 5000;
  // settle time after the last result, covers the longest walk
  localparam int DrainCycles = 300;
  localparam int RandomWords = 850;
  localparam int PhaseWords  = 50;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         cmd_i;
  logic [11:0]        year_in_i;
  logic [3:0]         month_in_i;
  logic [4:0]         day_in_i;
  logic [16:0]        count_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [11:0]        year_out_o;
  logic [3:0]         month_out_o;
  logic [4:0]         day_out_o;
  logic [16:0]        serial_out_o;
  logic signed [17:0] difference_o;

  int mismatches;
  int pending;
  int idle_pct;   // chance in percent that the sender skips a cycle
  int stall_pct;  // chance in percent that the receiver stalls a cycle

  calendar_date_arithmetic_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .year_in_i   (year_in_i),
    .month_in_i  (month_in_i),
    .day_in_i    (day_in_i),
    .count_in_i  (count_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .year_out_o  (year_out_o),
    .month_out_o (month_out_o),
    .day_out_o   (day_out_o),
    .serial_out_o(serial_out_o),
    .difference_o(difference_o)
  );

  // watches both channels, predicts every result word and counts mismatches
  calendar_date_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .cmd_i       (cmd_i),
    .year_in_i   (year_in_i),
    .month_in_i  (month_in_i),
    .day_in_i    (day_in_i),
    .count_in_i  (count_in_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .year_out_i  (year_out_o),
    .month_out_i (month_out_o),
    .day_out_i   (day_out_o),
    .serial_out_i(serial_out_o),
    .difference_i(difference_o),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side: a fresh stall decision at every falling edge
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog: any accepted word on either side restarts the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // offers one command word and returns at the falling edge after it is taken;
  // valid stays high into the next call so back to back words have no gap
  task automatic push_word(logic [2:0] c, logic [11:0] y, logic [3:0] m, logic [4:0] d,
                           logic [16:0] n);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = c;
    year_in_i  = y;
    month_in_i = m;
    day_in_i   = d;
    count_in_i = n;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // one random command: mostly well formed dates and modest counts, with
  // some raw field noise, zero fields and rare unused command codes
  task automatic push_random_word();
    int          pick;
    logic [2:0]  c;
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [16:0] n;
    pick = $urandom_range(0, 99);
    y    = 12'($urandom_range(cda_pkg::FirstYear, cda_pkg::LastYear));
    m    = 4'($urandom_range(1, 12));
    d    = 5'($urandom_range(1, 31));
    n    = 17'($urandom_range(0, 400));
    if (pick < 25)      c = cda_pkg::CMD_SET;
    else if (pick < 40) c = cda_pkg::CMD_LOAD;
    else if (pick < 58) c = cda_pkg::CMD_ADD;
    else if (pick < 76) c = cda_pkg::CMD_SUB;
    else if (pick < 95) c = cda_pkg::CMD_CMP;
    else                c = 3'($urandom_range(5, 7));
    // load wants a day number across the whole range
    if (c == cda_pkg::CMD_LOAD) n = 17'($urandom_range(0, cda_pkg::LastSerial + 10));
    // long jumps, some of them past either end of the range
    if ($urandom_range(0, 3) == 0) n = 17'($urandom_range(0, cda_pkg::LastSerial));
    // raw field noise covers every bit of the year, month and count fields
    if ($urandom_range(0, 9) == 0) y = 12'($urandom);
    if ($urandom_range(0, 9) == 0) m = 4'($urandom);
    if ($urandom_range(0, 9) == 0) n = 17'($urandom);
    // zero fields keep the stored value on set, count as bad on compare
    if ($urandom_range(0, 9) == 0) y = '0;
    if ($urandom_range(0, 9) == 0) m = '0;
    if ($urandom_range(0, 9) == 0) d = '0;
    push_word(c, y, m, d, n);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    cmd_i       = '0;
    year_in_i   = '0;
    month_in_i  = '0;
    day_in_i    = '0;
    count_in_i  = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words, no idling
    push_word(3'd5, 12'hfff, 4'hf, 5'h1f, 17'h1ffff);                 // unused code
    push_word(cda_pkg::CMD_SET, 12'd1900, 4'd1, 5'd1, 17'd0);          // first date
    push_word(cda_pkg::CMD_SET, 12'd2099, 4'd12, 5'd31, 17'd0);        // last date
    push_word(cda_pkg::CMD_SET, 12'd0, 4'd0, 5'd0, 17'd0);             // all fields kept
    push_word(cda_pkg::CMD_SET, 12'hfff, 4'hf, 5'h1f, 17'd0);          // bad fields
    push_word(cda_pkg::CMD_SET, 12'd1900, 4'd2, 5'd29, 17'd0);         // 1900 not leap
    push_word(cda_pkg::CMD_SET, 12'd2000, 4'd2, 5'd29, 17'd0);         // 2000 is
    push_word(cda_pkg::CMD_SET, 12'd0, 4'd0, 5'd31, 17'd0);            // month too short
    push_word(cda_pkg::CMD_LOAD, 12'd0, 4'd0, 5'd0, 17'd0);            // below range
    push_word(cda_pkg::CMD_LOAD, 12'd0, 4'd0, 5'd0, 17'd1);
    push_word(cda_pkg::CMD_LOAD, 12'd0, 4'd0, 5'd0, 17'd73049);
    push_word(cda_pkg::CMD_LOAD, 12'd0, 4'd0, 5'd0, 17'h1ffff);        // above range
    push_word(cda_pkg::CMD_LOAD, 12'd0, 4'd0, 5'd0, 17'd60);           // 1900-03-01
    push_word(cda_pkg::CMD_ADD, 12'd0, 4'd0, 5'd0, 17'h1ffff);         // saturates high
    push_word(cda_pkg::CMD_SUB, 12'd0, 4'd0, 5'd0, 17'h1ffff);         // saturates low
    push_word(cda_pkg::CMD_ADD, 12'd0, 4'd0, 5'd0, 17'd0);
    push_word(cda_pkg::CMD_SUB, 12'd0, 4'd0, 5'd0, 17'd0);
    push_word(cda_pkg::CMD_SET, 12'd2024, 4'd12, 5'd31, 17'd0);
    push_word(cda_pkg::CMD_ADD, 12'd0, 4'd0, 5'd0, 17'd1);             // across a year end
    push_word(cda_pkg::CMD_SUB, 12'd0, 4'd0, 5'd0, 17'd1);
    push_word(cda_pkg::CMD_CMP, 12'd1900, 4'd1, 5'd1, 17'd0);          // positive
    push_word(cda_pkg::CMD_CMP, 12'd2099, 4'd12, 5'd31, 17'd0);        // negative
    push_word(cda_pkg::CMD_CMP, 12'd0, 4'd0, 5'd0, 17'd0);             // zero fields bad
    push_word(cda_pkg::CMD_CMP, 12'hfff, 4'hf, 5'h1f, 17'd0);
    push_word(3'd7, 12'd0, 4'd0, 5'd0, 17'd0);

    // random words; pacing phases rotate through no gaps, sender idling, receiver stalls and a mix
    for (int i = 0; i < RandomWords; i++) begin
      if (i % PhaseWords == 0) begin
        case ((i / PhaseWords) % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 87; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 87; end
          default: begin idle_pct = 8; stall_pct = 8; end
        endcase
      end
      push_random_word();
    end
    in_valid_i = 1'b0;

    // let every outstanding result come back, then settle
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cda_pkg.sv
rtl/core/cda_walk.sv
rtl/core/calendar_date_arithmetic_unit.sv
tb/calendar_date_checker.sv
tb/tb_calendar_date_arithmetic_unit.sv
